// ----- hw/rtl/rot_pkg.sv -----
// ----------------------------------------------------------------------------
// rot_pkg
// Shared types and constants for the remote override thermostat.
// ----------------------------------------------------------------------------
`default_nettype none

package rot_pkg;

  // item kinds
  localparam logic [1:0] MODE_SERIAL = 2'd0;
  localparam logic [1:0] MODE_TEMP   = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;
  localparam logic [1:0] MODE_REPORT = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ON_THRESHOLD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_THRESHOLD = 1'd1;

  localparam int unsigned TEMP_W = 11;
  localparam logic signed [TEMP_W-1:0] ON_THRESHOLD_RST  = 11'sd240;
  localparam logic signed [TEMP_W-1:0] OFF_THRESHOLD_RST = 11'sd236;

  // line buffer: characters counted up to LINE_LIMIT, first LINE_KEEP kept
  localparam int unsigned LINE_LIMIT = 7;
  localparam int unsigned LINE_KEEP  = 5;
  localparam int unsigned LINE_CNT_W = $clog2(LINE_LIMIT + 1);
  localparam logic [LINE_CNT_W-1:0] LINE_LIMIT_CNT = LINE_CNT_W'(LINE_LIMIT);
  localparam logic [LINE_CNT_W-1:0] LINE_KEEP_CNT  = LINE_CNT_W'(LINE_KEEP);

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_V     = 8'h56;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // command decoded at end of line
  typedef struct packed {
    logic dc_set;
    logic dc_clr;
    logic sv_set;
    logic sv_clr;
    logic sv_raise;
  } line_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rot_line.sv -----
// ----------------------------------------------------------------------------
// rot_line
// Serial line buffer and command decoder. Decode is combinational on the
// current byte; the buffer updates when a serial byte is consumed.
// ----------------------------------------------------------------------------
`default_nettype none

module rot_line (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic [7:0]        rx_byte,
  output rot_pkg::line_cmd_t     cmd
);

  logic [7:0]                     line_chars [rot_pkg::LINE_KEEP];
  logic [rot_pkg::LINE_CNT_W-1:0] line_count;
  logic [rot_pkg::LINE_CNT_W-1:0] line_count_next;

  logic is_cr;
  logic is_lf;
  logic full_cmd;
  logic is_dc;
  logic is_sv;
  logic arg_one;
  logic arg_zero;

  assign is_cr    = (rx_byte == rot_pkg::CH_CR);
  assign is_lf    = (rx_byte == rot_pkg::CH_LF);
  assign full_cmd = (line_count >= rot_pkg::LINE_KEEP_CNT);

  assign is_dc = (line_chars[0] == rot_pkg::CH_BANG) && (line_chars[1] == rot_pkg::CH_D) &&
                 (line_chars[2] == rot_pkg::CH_C) && (line_chars[3] == rot_pkg::CH_COLON);
  assign is_sv = (line_chars[0] == rot_pkg::CH_BANG) && (line_chars[1] == rot_pkg::CH_S) &&
                 (line_chars[2] == rot_pkg::CH_V) && (line_chars[3] == rot_pkg::CH_COLON);
  assign arg_one  = (line_chars[4] == rot_pkg::CH_ONE);
  assign arg_zero = (line_chars[4] == rot_pkg::CH_ZERO);

  always_comb begin
    cmd = '0;
    if (is_lf && full_cmd) begin
      cmd.dc_set   = is_dc && arg_one;
      cmd.dc_clr   = is_dc && arg_zero;
      cmd.sv_set   = is_sv && arg_one;
      cmd.sv_clr   = is_sv && arg_zero;
      cmd.sv_raise = is_sv;
    end
  end

  always_comb begin
    line_count_next = line_count;
    if (is_cr) begin
      line_count_next = line_count;
    end else if (is_lf) begin
      line_count_next = '0;
    end else if (line_count < rot_pkg::LINE_LIMIT_CNT) begin
      line_count_next = line_count + 1'b1;
    end else begin
      // overflow empties the line, byte dropped
      line_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= '0;
    end else if (en) begin
      line_count <= line_count_next;
    end
  end

  // storage only, no reset: entries are read only after all were written
  always_ff @(posedge clk) begin
    for (int i = 0; i < rot_pkg::LINE_KEEP; i++) begin
      if (en && !is_cr && !is_lf && (line_count == rot_pkg::LINE_CNT_W'(i))) begin
        line_chars[i] <= rx_byte;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rot_cfg.sv -----
// ----------------------------------------------------------------------------
// rot_cfg
// Threshold register file written through the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rot_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output      logic                                cfg_ready,
  input  wire logic [rot_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [rot_pkg::TEMP_W-1:0]          cfg_data,
  output      logic signed [rot_pkg::TEMP_W-1:0]   on_threshold,
  output      logic signed [rot_pkg::TEMP_W-1:0]   off_threshold
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      on_threshold  <= rot_pkg::ON_THRESHOLD_RST;
      off_threshold <= rot_pkg::OFF_THRESHOLD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        rot_pkg::REG_ON_THRESHOLD:  on_threshold  <= $signed(cfg_data);
        rot_pkg::REG_OFF_THRESHOLD: off_threshold <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/remote_override_thermostat_core.sv -----
// ----------------------------------------------------------------------------
// remote_override_thermostat_core
// Remote override thermostat: serial commands, sensor words, ticks and
// servo delivery reports update a small control state; one result per item.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one item per transfer, selected by mode
// (serial byte, temperature word, timer tick, servo delivery report).
// Output channel (out_valid/out_ready): one result per item, holding motor,
// override, servo and last temperature state after that item.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 on threshold,
// index 1 off threshold, both signed eighths of a degree. Write only while
// no item is in flight.
// Path: an item passes the input register, then the state update into the
// result register.
// Throughput: one item per cycle; the input register refills in the same
// cycle its item moves into the result register.
// Stall: when out_ready is low the result holds, one more item waits in the
// input register, then in_ready drops.
// Reset: thresholds 240/236, all flags, line count and temperature zero.
// ----------------------------------------------------------------------------
`default_nettype none

module remote_override_thermostat_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // input channel
  input  wire logic                               in_valid,
  output      logic                               in_ready,
  input  wire logic [1:0]                         mode,
  input  wire logic [7:0]                         rx_byte,
  input  wire logic [15:0]                        temp_word,
  input  wire logic                               delivered,
  // result channel
  output      logic                               out_valid,
  input  wire logic                               out_ready,
  output      logic                               motor_on,
  output      logic                               fan_override,
  output      logic                               servo_near,
  output      logic                               servo_pending,
  output      logic signed [rot_pkg::TEMP_W-1:0]  temperature,
  // configuration channel
  input  wire logic                               cfg_valid,
  output      logic                               cfg_ready,
  input  wire logic [rot_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rot_pkg::TEMP_W-1:0]         cfg_data
);

  // input register
  logic        s1_valid;
  logic [1:0]  s1_mode;
  logic [7:0]  s1_rx_byte;
  logic [15:0] s1_temp_word;
  logic        s1_delivered;

  logic adv;

  // control state
  logic                               override_flag;
  logic                               servo_position;
  logic                               servo_waiting;
  logic                               motor_level;
  logic signed [rot_pkg::TEMP_W-1:0]  last_temperature;

  logic                               override_flag_next;
  logic                               servo_position_next;
  logic                               servo_waiting_next;
  logic                               motor_level_next;
  logic signed [rot_pkg::TEMP_W-1:0]  last_temperature_next;

  logic signed [rot_pkg::TEMP_W-1:0]  on_threshold;
  logic signed [rot_pkg::TEMP_W-1:0]  off_threshold;
  logic signed [rot_pkg::TEMP_W-1:0]  temp_new;

  rot_pkg::line_cmd_t cmd;

  assign adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_mode      <= mode;
      s1_rx_byte   <= rx_byte;
      s1_temp_word <= temp_word;
      s1_delivered <= delivered;
    end
  end

  rot_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .on_threshold  (on_threshold),
    .off_threshold (off_threshold)
  );

  rot_line u_line (
    .clk     (clk),
    .rst     (rst),
    .en      (adv && (s1_mode == rot_pkg::MODE_SERIAL)),
    .rx_byte (s1_rx_byte),
    .cmd     (cmd)
  );

  assign temp_new = $signed(s1_temp_word[15:5]);

  always_comb begin
    override_flag_next    = override_flag;
    servo_position_next   = servo_position;
    servo_waiting_next    = servo_waiting;
    motor_level_next      = motor_level;
    last_temperature_next = last_temperature;
    case (s1_mode)
      rot_pkg::MODE_SERIAL: begin
        if (cmd.dc_set) begin
          override_flag_next = 1'b1;
        end else if (cmd.dc_clr) begin
          override_flag_next = 1'b0;
        end
        if (cmd.sv_set) begin
          servo_position_next = 1'b1;
        end else if (cmd.sv_clr) begin
          servo_position_next = 1'b0;
        end
        if (cmd.sv_raise) begin
          servo_waiting_next = 1'b1;
        end
      end
      rot_pkg::MODE_TEMP: begin
        last_temperature_next = temp_new;
        // hysteresis, on test first
        if (!override_flag) begin
          if (temp_new >= on_threshold) begin
            motor_level_next = 1'b1;
          end else if (temp_new <= off_threshold) begin
            motor_level_next = 1'b0;
          end
        end
      end
      rot_pkg::MODE_TICK: begin
        if (override_flag) begin
          motor_level_next = 1'b1;
        end
      end
      rot_pkg::MODE_REPORT: begin
        if (s1_delivered) begin
          servo_waiting_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      override_flag    <= 1'b0;
      servo_position   <= 1'b0;
      servo_waiting    <= 1'b0;
      motor_level      <= 1'b0;
      last_temperature <= '0;
    end else if (adv) begin
      override_flag    <= override_flag_next;
      servo_position   <= servo_position_next;
      servo_waiting    <= servo_waiting_next;
      motor_level      <= motor_level_next;
      last_temperature <= last_temperature_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      motor_on      <= motor_level_next;
      fan_override  <= override_flag_next;
      servo_near    <= servo_position_next;
      servo_pending <= servo_waiting_next;
      temperature   <= last_temperature_next;
    end
  end

  // ---------------------------------------------------------------------
  a_adv_gives_result: assert property (@(posedge clk) disable iff (rst)
    adv |=> out_valid)
    else $error("result missing after advance");

  a_empty_out_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_tick_override: assert property (@(posedge clk) disable iff (rst)
    (adv && (s1_mode == rot_pkg::MODE_TICK) && override_flag) |=> motor_on)
    else $error("tick under override did not drive motor");

  a_report_clears: assert property (@(posedge clk) disable iff (rst)
    (adv && (s1_mode == rot_pkg::MODE_REPORT) && s1_delivered) |=> !servo_pending)
    else $error("delivery report did not clear pending");

endmodule

`default_nettype wire

// ----- bench/thermostat_checker.sv -----
// ----------------------------------------------------------------------------
// thermostat_checker
// Watches the item, result and configuration channels of the thermostat
// core, tracks the control state on its own and compares every result
// transfer field by field with the status predicted for the oldest item.
// ----------------------------------------------------------------------------
module thermostat_checker import rot_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [1:0]               mode,
  input  logic [7:0]               rx_byte,
  input  logic [15:0]              temp_word,
  input  logic                     delivered,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic                     motor_on,
  input  logic                     fan_override,
  input  logic                     servo_near,
  input  logic                     servo_pending,
  input  logic signed [TEMP_W-1:0] temperature,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [TEMP_W-1:0]        cfg_data,
  output int                       mismatches,
  output int                       backlog
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                     motor;
    logic                     fan;
    logic                     near;
    logic                     pending;
    logic signed [TEMP_W-1:0] temp;
  } thermo_status_t;

  logic [7:0]               line_buf [LINE_KEEP];
  int unsigned              line_len;
  logic                     fan_flag;
  logic                     servo_pos;
  logic                     servo_wait;
  logic                     motor_lvl;
  logic signed [TEMP_W-1:0] last_temp;
  logic signed [TEMP_W-1:0] on_thr;
  logic signed [TEMP_W-1:0] off_thr;
  thermo_status_t           status_q [$];
  thermo_status_t           want;

  function automatic thermo_status_t next_status(input logic [1:0] m, input logic [7:0] ch,
                                                 input logic [15:0] tw, input logic dl);
    logic signed [TEMP_W-1:0] t;
    logic                     is_dc;
    logic                     is_sv;
    t = tw[15:5];
    case (m)
      MODE_SERIAL: begin
        if (ch == CH_LF) begin
          // only a line holding at least the five kept characters can be a command
          if (line_len >= LINE_KEEP) begin
            is_dc = line_buf[0] == CH_BANG && line_buf[1] == CH_D &&
                    line_buf[2] == CH_C && line_buf[3] == CH_COLON;
            is_sv = line_buf[0] == CH_BANG && line_buf[1] == CH_S &&
                    line_buf[2] == CH_V && line_buf[3] == CH_COLON;
            if (is_dc && line_buf[4] == CH_ONE) fan_flag = 1'b1;
            else if (is_dc && line_buf[4] == CH_ZERO) fan_flag = 1'b0;
            if (is_sv) begin
              if (line_buf[4] == CH_ONE) servo_pos = 1'b1;
              else if (line_buf[4] == CH_ZERO) servo_pos = 1'b0;
              servo_wait = 1'b1;
            end
          end
          line_len = 0;
        end else if (ch != CH_CR) begin
          if (line_len < LINE_LIMIT) begin
            if (line_len < LINE_KEEP) line_buf[line_len] = ch;
            line_len++;
          end else begin
            line_len = 0;
          end
        end
      end
      MODE_TEMP: begin
        last_temp = t;
        // on test wins when the thresholds cross
        if (!fan_flag) begin
          if (t >= on_thr) motor_lvl = 1'b1;
          else if (t <= off_thr) motor_lvl = 1'b0;
        end
      end
      MODE_TICK: begin
        if (fan_flag) motor_lvl = 1'b1;
      end
      MODE_REPORT: begin
        if (dl) servo_wait = 1'b0;
      end
    endcase
    return '{motor_lvl, fan_flag, servo_pos, servo_wait, last_temp};
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      line_len   = 0;
      fan_flag   = 1'b0;
      servo_pos  = 1'b0;
      servo_wait = 1'b0;
      motor_lvl  = 1'b0;
      last_temp  = '0;
      on_thr     = ON_THRESHOLD_RST;
      off_thr    = OFF_THRESHOLD_RST;
      status_q.delete();
      mismatches = 0;
      backlog    = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          $error("result transfer with no item outstanding");
          mismatches++;
        end else begin
          want = status_q.pop_front();
          check_field("motor_on", want.motor, motor_on);
          check_field("fan_override", want.fan, fan_override);
          check_field("servo_near", want.near, servo_near);
          check_field("servo_pending", want.pending, servo_pending);
          check_field("temperature", int'(want.temp), int'(temperature));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ON_THRESHOLD) on_thr = cfg_data;
        else if (cfg_index == REG_OFF_THRESHOLD) off_thr = cfg_data;
      end
      if (in_valid && in_ready)
        status_q.push_back(next_status(mode, rx_byte, temp_word, delivered));
      backlog = status_q.size();
    end
  end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives the thermostat core with serial command lines, sensor words, ticks
// and delivery reports under random stalls on both channels, across several
// threshold settings; the checker beside the core predicts every result.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rot_pkg::*;

  localparam int WATCH_LIMIT = 2000;
  localparam int PHASE_ITEMS = 270;
  localparam int PHASES      = 6;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               mode;
  logic [7:0]               rx_byte;
  logic [15:0]              temp_word;
  logic                     delivered;
  logic                     out_valid;
  logic                     out_ready;
  logic                     motor_on;
  logic                     fan_override;
  logic                     servo_near;
  logic                     servo_pending;
  logic signed [TEMP_W-1:0] temperature;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [TEMP_W-1:0]        cfg_data;

  int mismatches;
  int backlog;
  int items_sent;
  int gap_pct;
  int stall_pct;
  int stall_left;
  int idle_cycles;
  int target;
  logic signed [TEMP_W-1:0] on_level;
  logic signed [TEMP_W-1:0] off_level;

  remote_override_thermostat_core DUT (.*);

  thermostat_checker status_check (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side: random bursts of out_ready held low
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
        out_ready  = 1'b0;
        stall_left = $urandom_range(14);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCH_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // fields outside the item's mode get random values
  task automatic send_item(input logic [1:0] m, input int unsigned value);
    @(negedge clk);
    in_valid  = 1'b1;
    mode      = m;
    rx_byte   = 8'($urandom);
    temp_word = 16'($urandom);
    delivered = 1'($urandom);
    case (m)
      MODE_SERIAL: rx_byte = value[7:0];
      MODE_TEMP:   temp_word = value[15:0];
      MODE_REPORT: delivered = value[0];
      default: ;
    endcase
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(14)) @(negedge clk);
    end
  endtask

  task automatic send_line(input string s);
    for (int i = 0; i < s.len(); i++) send_item(MODE_SERIAL, s[i]);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TEMP_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // hold off the sender until every outstanding result has come back
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (backlog != 0) @(negedge clk);
  endtask

  task automatic random_traffic();
    int          pick;
    int          count;
    int          cr_at;
    logic [7:0]  body [$];
    logic [7:0]  arg;
    logic [10:0] t;
    logic        is_dc;
    pick = $urandom_range(99);
    if (pick < 40) begin
      // mostly well-formed command lines, some corrupted, cut short or overlong
      is_dc = 1'($urandom_range(1));
      arg   = $urandom_range(9) < 4 ? CH_ONE : CH_ZERO;
      if ($urandom_range(9) == 0) arg = 8'($urandom);
      body = {CH_BANG, is_dc ? CH_D : CH_S, is_dc ? CH_C : CH_V, CH_COLON, arg};
      if ($urandom_range(9) == 0) body[$urandom_range(4)] = 8'($urandom);
      repeat ($urandom_range(3)) body.push_back(8'($urandom_range(126, 32)));
      count = body.size();
      if ($urandom_range(11) == 0) count = $urandom_range(4, 1);
      cr_at = $urandom_range(20);
      if ($urandom_range(1)) send_item(MODE_SERIAL, CH_LF);
      for (int i = 0; i < count; i++) begin
        if (i == cr_at) send_item(MODE_SERIAL, CH_CR);
        send_item(MODE_SERIAL, body[i]);
      end
      send_item(MODE_SERIAL, CH_LF);
    end else if (pick < 65) begin
      // keep most readings around the thresholds to work the hysteresis
      if ($urandom_range(9) < 7) begin
        t = 11'(($urandom_range(1) ? on_level : off_level) + $urandom_range(6) - 3);
        send_item(MODE_TEMP, {t, 5'($urandom)});
      end else begin
        send_item(MODE_TEMP, $urandom);
      end
    end else if (pick < 75) begin
      send_item(MODE_TICK, $urandom);
    end else if (pick < 85) begin
      send_item(MODE_REPORT, $urandom_range(1));
    end else begin
      repeat ($urandom_range(4, 1)) begin
        pick = $urandom_range(9);
        if (pick < 2) send_item(MODE_SERIAL, CH_LF);
        else if (pick == 2) send_item(MODE_SERIAL, 0);
        else if (pick == 3) send_item(MODE_SERIAL, CH_CR);
        else send_item(MODE_SERIAL, $urandom_range(255));
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    mode       = MODE_SERIAL;
    rx_byte    = '0;
    temp_word  = '0;
    delivered  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_ON_THRESHOLD;
    cfg_data   = '0;
    on_level   = ON_THRESHOLD_RST;
    off_level  = OFF_THRESHOLD_RST;
    items_sent = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: temperature extremes and hysteresis on reset thresholds
    send_item(MODE_TEMP, 16'h7FE0);
    send_item(MODE_TEMP, 16'h801F);
    send_item(MODE_TEMP, 240 << 5);
    send_item(MODE_TEMP, 238 << 5);
    send_item(MODE_TEMP, 236 << 5);
    send_item(MODE_TICK, $urandom);
    // override on: readings no longer move the motor, a tick forces it on
    send_line("!DC:1");
    send_item(MODE_SERIAL, CH_LF);
    send_item(MODE_TEMP, 16'h7FE0);
    send_item(MODE_TICK, $urandom);
    // servo with an odd argument still raises pending; carriage return ignored
    send_line("!SV:2");
    send_item(MODE_SERIAL, CH_CR);
    send_item(MODE_SERIAL, CH_LF);
    send_item(MODE_REPORT, 0);
    send_item(MODE_REPORT, 1);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          on_level  = TEMP_W'(1023);
          off_level = TEMP_W'(-1024);
          gap_pct   = 10;
          stall_pct = 20;
        end
        1: begin
          on_level  = TEMP_W'(-1024);
          off_level = TEMP_W'(1023);
          gap_pct   = 30;
          stall_pct = 10;
        end
        2: begin on_level = '0; off_level = '0; gap_pct = 0; stall_pct = 30; end
        3: begin
          on_level  = TEMP_W'($urandom_range(400) - 200);
          off_level = TEMP_W'(on_level - $urandom_range(16));
          gap_pct   = 20;
          stall_pct = 0;
        end
        4: begin
          on_level  = TEMP_W'(-1);
          off_level = TEMP_W'(-8);
          gap_pct   = 50;
          stall_pct = 40;
        end
        default: begin
          on_level  = ON_THRESHOLD_RST;
          off_level = OFF_THRESHOLD_RST;
          gap_pct   = 0;
          stall_pct = 0;
        end
      endcase
      write_reg(REG_ON_THRESHOLD, on_level);
      write_reg(REG_OFF_THRESHOLD, off_level);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) random_traffic();
      drain();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0 && backlog == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/rot_pkg.sv
hw/rtl/rot_line.sv
hw/rtl/rot_cfg.sv
hw/rtl/remote_override_thermostat_core.sv
bench/thermostat_checker.sv
bench/testbench.sv
